### rtl/min_tracking_stack_assert.svh
// ----------------------------------------------------------------------------
// min_tracking_stack assertion macros
// Shared property forms for the stack's port checker.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_USED_W  = 2 * DATA_W + 2 + COUNT_W;

  localparam logic signed [DATA_W-1:0] EMPTY_CODE = '1;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] min_below;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

### rtl/mts_cell.sv
// ----------------------------------------------------------------------------
// mts_cell
// One stack slot: value plus minimum of itself and all slots below it.
// ----------------------------------------------------------------------------
module mts_cell (
  input  logic                clk,
  input  mts_pkg::cell_ctrl_t ctrl,
  input  mts_pkg::entry_t     upper_entry,
  input  mts_pkg::entry_t     lower_entry,
  output mts_pkg::entry_t     entry
);
  import mts_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      entry_nxt = upper_entry;
    end else if (ctrl.pop) begin
      entry_nxt = lower_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO of signed 32-bit values that reports the minimum of its contents.
// ----------------------------------------------------------------------------
// Input channel: in_tuser selects push (0) or pop (1); in_tdata carries the
// value to push. Each request yields exactly one result on the out channel:
// popped value, minimum after the step, pop-empty and push-overflow flags
// and the entry count after the step.
// Storage is a row of cells, top of stack in cell 0; a push shifts every
// cell down by one and a pop shifts every cell up, so each request is done
// in one shift; its registered result appears the cycle after acceptance.
// Throughput is one request per cycle; a result register sits between the
// sides and a new request is taken whenever that register is empty or is
// being drained in the same cycle.
// Reset clears the entry count and the result valid; no clearing pass over
// the cells. When the receiver stalls, the result holds and in_tready drops
// until it is taken. A pop of an empty stack and a push to a full one leave
// the contents unchanged and are flagged in the result.
// ----------------------------------------------------------------------------
module min_tracking_stack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mts_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] push_value
  input  logic                                in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] popped_value, [63:32] current_min, [64] pop_was_empty,
  // [65] push_overflow, [72:66] entry_count, [79:73] zero
  output logic [mts_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import mts_pkg::*;

  entry_t     cell_q [STACK_DEPTH];
  entry_t     new_entry;
  cell_ctrl_t ctrl;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_tvalid_r;
  logic                     out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_nxt;

  logic                     accept;
  action_t                  action;
  logic signed [DATA_W-1:0] push_value;
  logic signed [DATA_W-1:0] res_popped;
  logic signed [DATA_W-1:0] res_min;
  logic                     res_empty;
  logic                     res_overflow;
  logic                     is_empty;
  logic                     is_full;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign action     = action_t'(in_tuser);
  assign push_value = in_tdata[DATA_W-1:0];
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == CNT_W'(STACK_DEPTH));

  always_comb begin
    new_entry.value     = push_value;
    new_entry.min_below = push_value;
    if (!is_empty && (cell_q[0].min_below < push_value)) begin
      new_entry.min_below = cell_q[0].min_below;
    end
  end

  always_comb begin
    ctrl         = '0;
    count_nxt    = count_r;
    res_popped   = EMPTY_CODE;
    res_min      = is_empty ? EMPTY_CODE : cell_q[0].min_below;
    res_empty    = 1'b0;
    res_overflow = 1'b0;
    case (action)
      ACT_PUSH: begin
        if (is_full) begin
          res_overflow = 1'b1;
        end else begin
          ctrl.push = accept;
          count_nxt = count_r + CNT_W'(1);
          res_min   = new_entry.min_below;
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          res_empty = 1'b1;
        end else begin
          ctrl.pop   = accept;
          count_nxt  = count_r - CNT_W'(1);
          res_popped = cell_q[0].value;
          res_min    = (count_r == CNT_W'(1)) ? EMPTY_CODE : cell_q[1].min_below;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      entry_t upper;
      entry_t lower;
      if (gi == 0) begin : g_top
        assign upper = new_entry;
      end else begin : g_mid
        assign upper = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_bot
        assign lower = cell_q[gi];
      end else begin : g_nbot
        assign lower = cell_q[gi+1];
      end
      mts_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .upper_entry (upper),
        .lower_entry (lower),
        .entry       (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    out_tvalid_nxt = accept || (out_tvalid_r && !out_tready);
    out_tdata_nxt  = out_tdata_r;
    if (accept) begin
      out_tdata_nxt = {(OUT_TDATA_W - OUT_USED_W)'(0), COUNT_W'(count_nxt),
                       res_overflow, res_empty, res_min, res_popped};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= accept ? count_nxt : count_r;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks for the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_assert.svh"

module mts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mts_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mts_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mts_pkg::*;

  `MTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")

  `MTS_ASSERT_NOW(a_ready_when_free, clk, rst_n, !out_tvalid,
    in_tready, "request refused with result register empty")

  `MTS_ASSERT_NOW(a_empty_pop, clk, rst_n, out_tvalid && out_tdata[64],
    out_tdata[31:0] == 32'hFFFF_FFFF && out_tdata[63:32] == 32'hFFFF_FFFF &&
    out_tdata[72:66] == 7'd0 && !out_tdata[65], "bad empty pop result")

  `MTS_ASSERT_NOW(a_overflow, clk, rst_n, out_tvalid && out_tdata[65],
    out_tdata[31:0] == 32'hFFFF_FFFF && !out_tdata[64], "bad overflow result")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

### tb/min_tracking_stack_tb.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Self-checking bench for the min tracking stack.
// ----------------------------------------------------------------------------
// Pushes and pops go in on the input stream. A shadow stack keeps each value
// and the running minimum below it, and it predicts one result per accepted
// request. Results are matched in order, field by field. The run covers
// directed edge values, empty pops, a fill past full, a long output stall
// and a biased random walk over the whole depth. Both sides idle at random
// until the last part, which runs at full rate.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int STALL_CYCLES = 200;

  typedef struct {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] cur_min;
    logic                     was_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       count;
  } stack_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic signed [DATA_W-1:0] shadow_value [STACK_DEPTH];
  logic signed [DATA_W-1:0] shadow_min   [STACK_DEPTH];
  int                       shadow_depth = 0;
  stack_result_t            awaited_results[$];

  int mismatch_count = 0;
  bit idle_en        = 1'b1;
  bit stall_req      = 1'b0;

  min_tracking_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic stack_result_t apply_stack_op(input action_t act,
                                                   input logic signed [DATA_W-1:0] v);
    stack_result_t r;
    logic signed [DATA_W-1:0] m;
    r.popped    = EMPTY_CODE;
    r.was_empty = 1'b0;
    r.overflow  = 1'b0;
    if (act == ACT_PUSH) begin
      if (shadow_depth >= STACK_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        m = v;
        if (shadow_depth > 0 && shadow_min[shadow_depth-1] < m) m = shadow_min[shadow_depth-1];
        shadow_value[shadow_depth] = v;
        shadow_min[shadow_depth]   = m;
        shadow_depth++;
      end
    end else begin
      if (shadow_depth == 0) begin
        r.was_empty = 1'b1;
      end else begin
        shadow_depth--;
        r.popped = shadow_value[shadow_depth];
      end
    end
    r.cur_min = (shadow_depth == 0) ? EMPTY_CODE : shadow_min[shadow_depth-1];
    r.count   = shadow_depth[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) return $urandom();
    if (kind < 8) return DATA_W'($signed($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_request(input action_t act, input logic [DATA_W-1:0] value);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(apply_stack_op(act, value));
  endtask

  task automatic push_item(input logic [DATA_W-1:0] value);
    send_request(ACT_PUSH, value);
  endtask

  task automatic pop_item();
    send_request(ACT_POP, $urandom());
  endtask

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t on %s: expected %0d (%h), got %0d (%h)", $realtime, field,
               $signed(want), want, $signed(got), got);
  endtask

  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at %0t: %h", $realtime, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[31:0] !== want.popped)
          note_mismatch("popped_value", want.popped, out_tdata[31:0]);
        if (out_tdata[63:32] !== want.cur_min)
          note_mismatch("current_min", want.cur_min, out_tdata[63:32]);
        if (out_tdata[64] !== want.was_empty)
          note_mismatch("pop_was_empty", DATA_W'(want.was_empty), DATA_W'(out_tdata[64]));
        if (out_tdata[65] !== want.overflow)
          note_mismatch("push_overflow", DATA_W'(want.overflow), DATA_W'(out_tdata[65]));
        if (out_tdata[72:66] !== want.count)
          note_mismatch("entry_count", DATA_W'(want.count), DATA_W'(out_tdata[72:66]));
      end
    end
  end

  initial begin : receiver
    forever begin
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic test_edge_values();
    pop_item();
    push_item(32'h7FFF_FFFF);
    push_item(32'h8000_0000);
    push_item(32'h0000_0000);
    push_item(32'hFFFF_FFFF);
    push_item(32'h8000_0000);
    push_item(32'h0000_0005);
    pop_item();
    pop_item();
    pop_item();
    pop_item();
    pop_item();
    pop_item();
    pop_item();
    push_item(32'h5555_5555);
    push_item(32'hAAAA_AAAA);
    pop_item();
    pop_item();
    pop_item();
  endtask

  task automatic test_fill_overflow();
    while (shadow_depth < STACK_DEPTH) push_item(pick_value());
    push_item(32'h8000_0000);
    push_item(32'h7FFF_FFFF);
    push_item($urandom());
    pop_item();
    pop_item();
    push_item(32'h8000_0000);
    push_item($urandom());
    push_item(32'hFFFF_FFFF);
    while (shadow_depth > 0) pop_item();
    pop_item();
    pop_item();
  endtask

  task automatic test_output_stall();
    stall_req = 1'b1;
    repeat (16) begin
      if ($urandom_range(0, 2) != 0) push_item(pick_value());
      else pop_item();
    end
  endtask

  task automatic test_random_walk(input int count);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 50;
          2:       push_pct = 75;
          default: push_pct = 95;
        endcase
      end
      if ($urandom_range(1, 100) <= push_pct) push_item(pick_value());
      else pop_item();
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    test_random_walk(250);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_fill_overflow();
    test_output_stall();
    test_random_walk(1075);
    test_full_rate();

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
